// ===== rtl/bgca_pkg.sv =====
// shared types and constants for the binary grid cellular automaton
// request/response word layouts, register indexes, neighborhood walk tables
// no dependencies
package bgca_pkg;

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_ADDR_W-1:0] CFG_MAP_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAP_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PASS_COUNT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SURVIVE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIRTH      = 3'd4;

  // register reset values
  localparam logic [6:0] RST_MAP_WIDTH  = 7'd64;
  localparam logic [6:0] RST_MAP_HEIGHT = 7'd64;
  localparam logic [3:0] RST_PASS_COUNT = 4'd3;
  localparam logic [3:0] RST_SURVIVE    = 4'd4;
  localparam logic [3:0] RST_BIRTH      = 4'd5;

  // smallest usable grid dimension
  localparam int unsigned DIM_MIN = 3;

  // 3x3 neighborhood walk: taps 0..8 in raster order, tap 4 is the cell itself
  localparam logic [3:0] NB_TAPS   = 4'd9;
  localparam logic [3:0] NB_CENTER = 4'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] cell_index;
    logic        in_wall;
  } req_t;

  typedef struct packed {
    logic out_wall;
    logic index_error;
    logic run_done;
  } rsp_t;

  // row of a tap: 0 above, 1 same row, 2 below
  function automatic logic [1:0] nb_row(input logic [3:0] tap);
    logic [1:0] r;
    case (tap) inside
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // column of a tap: 0 left, 1 same column, 2 right
  function automatic logic [1:0] nb_col(input logic [3:0] tap);
    logic [1:0] c;
    case (tap) inside
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/bgca_grid_ram.sv =====
// single-bit cell store, one write port and one read port
// read data registered; contents undefined until written; no dependencies
module bgca_grid_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/binary_grid_cellular_automaton.sv =====
// cave-shaping 4-5 automaton over a wall/floor bitmap held in one cell ram
// write word: ram write on accept, then S_DONE; read word: ram read on accept, then S_READ and S_DONE
// run word: one border walk, then per pass a walk over the interior cells (nine
//   ram reads plus one write per cell), then a second border walk when passes > 0,
//   then S_DONE; one word in flight at a time, so a new word is taken only after
//   the last result has left S_DONE
// async active-low reset clears control and config; cell ram is not cleared
module binary_grid_cellular_automaton
  import bgca_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  req_t                  in_req_i,
  // response channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rsp_t                  out_rsp_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = $clog2(MAX_WIDTH + 1);   // width value
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);  // height value
  localparam int unsigned XW    = $clog2(MAX_WIDTH);       // column index
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);      // row index
  localparam int unsigned CW    = DW + HW;                 // cell count
  localparam int unsigned PW    = (CW > 12) ? CW : 12;     // index compare

  // one-hot sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_BORDER = 5'b00100,
    S_PASS   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [6:0] map_width_q, map_height_q;
  logic [3:0] pass_count_q, survive_q, birth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= RST_MAP_WIDTH;
      map_height_q <= RST_MAP_HEIGHT;
      pass_count_q <= RST_PASS_COUNT;
      survive_q    <= RST_SURVIVE;
      birth_q      <= RST_BIRTH;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_wdata_i;
        CFG_MAP_HEIGHT: map_height_q <= cfg_wdata_i;
        CFG_PASS_COUNT: pass_count_q <= cfg_wdata_i[3:0];
        CFG_SURVIVE:    survive_q    <= cfg_wdata_i[3:0];
        CFG_BIRTH:      birth_q      <= cfg_wdata_i[3:0];
        default: ;  // unknown index: no effect
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // grid geometry: dimensions saturate to DIM_MIN..MAX
  // ---------------------------------------------------------------------------
  logic [DW-1:0] width_c;
  logic [HW-1:0] height_c;
  logic [CW-1:0] cells_c;
  logic          index_bad;
  logic [XW-1:0] wm1, wm2;     // last column, last interior column
  logic [YW-1:0] hm1, hm2;     // last row, last interior row
  logic [AW-1:0] row_step;     // address distance between rows

  always_comb begin
    if (map_width_q < 7'(DIM_MIN)) begin
      width_c = DW'(DIM_MIN);
    end else if (int'(map_width_q) > int'(MAX_WIDTH)) begin
      width_c = DW'(MAX_WIDTH);
    end else begin
      width_c = DW'(map_width_q);
    end
    if (map_height_q < 7'(DIM_MIN)) begin
      height_c = HW'(DIM_MIN);
    end else if (int'(map_height_q) > int'(MAX_HEIGHT)) begin
      height_c = HW'(MAX_HEIGHT);
    end else begin
      height_c = HW'(map_height_q);
    end
  end

  assign cells_c   = CW'(width_c) * CW'(height_c);
  assign index_bad = PW'(in_req_i.cell_index) >= PW'(cells_c);
  assign wm1       = XW'(width_c - DW'(1));
  assign wm2       = XW'(width_c - DW'(2));
  assign hm1       = YW'(height_c - HW'(1));
  assign hm2       = YW'(height_c - HW'(2));
  assign row_step  = AW'(width_c);

  // ---------------------------------------------------------------------------
  // cell ram
  // ---------------------------------------------------------------------------
  logic          ram_we, ram_wdata, ram_re, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;

  bgca_grid_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // sequencer state
  // ---------------------------------------------------------------------------
  state_e        state_q, state_d;
  logic          out_valid_q, out_valid_d;
  logic          final_q, final_d;        // second border walk of a run
  logic [3:0]    tap_q, tap_d;            // neighborhood step, 0..NB_TAPS
  logic [3:0]    pass_idx_q, pass_idx_d;
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [AW-1:0] row_q, row_d;            // address of column 0 of row y
  logic [3:0]    cnt_q, cnt_d;            // wall neighbors so far
  logic          center_q, center_d;
  rsp_t          res_q, res_d;
  rsp_t          out_q, out_d;

  // neighbor address for the current tap
  logic [1:0]    nb_dy, nb_dx;
  logic [AW-1:0] nb_base, nb_addr, cur_addr;
  logic [3:0]    nb_total;
  logic          new_wall;
  logic          out_free;

  always_comb begin
    nb_dy = nb_row(tap_q);
    nb_dx = nb_col(tap_q);
    if (nb_dy == 2'd0) begin
      nb_base = row_q - row_step;
    end else if (nb_dy == 2'd2) begin
      nb_base = row_q + row_step;
    end else begin
      nb_base = row_q;
    end
  end

  assign nb_addr  = nb_base + AW'(x_q) + AW'(nb_dx) - AW'(1);
  assign cur_addr = row_q + AW'(x_q);
  // last tap (lower right) arrives in the write cycle
  assign nb_total = cnt_q + {3'b000, ram_rdata};
  assign new_wall = center_q ? (nb_total >= survive_q) : (nb_total >= birth_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    final_d     = final_q;
    tap_d       = tap_q;
    pass_idx_d  = pass_idx_q;
    x_d         = x_q;
    y_d         = y_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    center_d    = center_q;
    res_d       = res_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_addr;
    ram_wdata   = 1'b1;
    ram_re      = 1'b0;
    ram_raddr   = nb_addr;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d   = '0;
          state_d = S_DONE;
          case (in_req_i.req_type)
            REQ_WRITE: begin
              if (index_bad) begin
                res_d.index_error = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(in_req_i.cell_index);
                ram_wdata = in_req_i.in_wall;
              end
            end
            REQ_READ: begin
              res_d.index_error = index_bad;
              ram_re            = !index_bad;
              ram_raddr         = AW'(in_req_i.cell_index);
              state_d           = S_READ;
            end
            REQ_RUN: begin
              res_d.run_done = 1'b1;
              final_d        = 1'b0;
              x_d            = '0;
              y_d            = '0;
              row_d          = '0;
              state_d        = S_BORDER;
            end
            default: ;  // unknown request: all-zero result
          endcase
        end
      end

      S_READ: begin
        // stale ram data is masked on a bad index
        res_d.out_wall = ram_rdata && !res_q.index_error;
        state_d        = S_DONE;
      end

      S_BORDER: begin
        // walk top and bottom rows fully, middle rows at both ends only
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = 1'b1;
        if (x_q == wm1) begin
          x_d   = '0;
          y_d   = y_q + YW'(1);
          row_d = row_q + row_step;
          if (y_q == hm1) begin
            if (final_q || pass_count_q == 4'd0) begin
              state_d = S_DONE;
            end else begin
              x_d        = XW'(1);
              y_d        = YW'(1);
              row_d      = row_step;
              tap_d      = '0;
              cnt_d      = '0;
              pass_idx_d = '0;
              state_d    = S_PASS;
            end
          end
        end else if (y_q == '0 || y_q == hm1) begin
          x_d = x_q + XW'(1);
        end else begin
          x_d = wm1;
        end
      end

      S_PASS: begin
        // taps issued at tap steps 0..8, registered read data lands in the step after
        if (tap_q != NB_TAPS) begin
          ram_re    = 1'b1;
          ram_raddr = nb_addr;
          tap_d     = tap_q + 4'd1;
        end
        if (tap_q != 4'd0 && tap_q != NB_TAPS) begin
          if (tap_q == NB_CENTER + 4'd1) begin
            center_d = ram_rdata;
          end else begin
            cnt_d = cnt_q + {3'b000, ram_rdata};
          end
        end
        if (tap_q == NB_TAPS) begin
          // in-place update: later cells in this pass see the new value
          ram_we    = 1'b1;
          ram_waddr = cur_addr;
          ram_wdata = new_wall;
          tap_d     = '0;
          cnt_d     = '0;
          if (x_q == wm2) begin
            x_d   = XW'(1);
            y_d   = y_q + YW'(1);
            row_d = row_q + row_step;
            if (y_q == hm2) begin
              y_d   = YW'(1);
              row_d = row_step;
              if (4'(pass_idx_q + 4'd1) == pass_count_q) begin
                x_d     = '0;
                y_d     = '0;
                row_d   = '0;
                final_d = 1'b1;
                state_d = S_BORDER;
              end else begin
                pass_idx_d = pass_idx_q + 4'd1;
              end
            end
          end else begin
            x_d = x_q + XW'(1);
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      final_q     <= 1'b0;
      tap_q       <= '0;
      pass_idx_q  <= '0;
      x_q         <= '0;
      y_q         <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      final_q     <= final_d;
      tap_q       <= tap_d;
      pass_idx_q  <= pass_idx_d;
      x_q         <= x_d;
      y_q         <= y_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    center_q <= center_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
